// ===== hdl/mess_pkg.sv =====
// Shared types and constants for the square-wave music event synthesiser.
// No dependencies; used by every module in hdl/.
package mess_pkg;

	localparam logic [1:0] KIND_SCORE   = 2'd0;
	localparam logic [1:0] KIND_RENDER  = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	localparam logic [0:0] REG_VOLUME = 1'd0;
	localparam logic [0:0] REG_BURST  = 1'd1;

	// Event types carried in bits 6:4 of a descriptor.
	localparam logic [2:0] EV_RELEASE = 3'd0;
	localparam logic [2:0] EV_PRESS   = 3'd1;
	localparam logic [2:0] EV_PITCH   = 3'd2;
	localparam logic [2:0] EV_SYSTEM  = 3'd3;
	localparam logic [2:0] EV_CTRL    = 3'd4;

	localparam logic [3:0] DRUM_CHANNEL = 4'd15;
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;
	localparam logic [31:0] SEED_RESET = 32'd12345;
	localparam logic [7:0] VOLUME_RESET = 8'd100;
	localparam logic [15:0] BURST_RESET = 16'd551;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] score_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  sample;
		logic        sample_valid;
		logic        delta_valid;
		logic [31:0] delta_ticks;
		logic        score_end;
		logic [4:0]  voice_count;
	} out_item_t;

	// Parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_DESC    = 6'b000001,
		PH_RELEASE = 6'b000010,
		PH_PRESS   = 6'b000100,
		PH_VELO    = 6'b001000,
		PH_SKIP    = 6'b010000,
		PH_DELTA   = 6'b100000
	} phase_t;

	// Back-end sequencer states, one-hot.
	typedef enum logic [5:0] {
		BE_IDLE  = 6'b000001,
		BE_VOICE = 6'b000010,
		BE_NOISE = 6'b000100,
		BE_MUL   = 6'b001000,
		BE_DIV   = 6'b010000,
		BE_OUT   = 6'b100000
	} be_state_t;

	// Command handed from the front part to the back part.
	typedef struct packed {
		logic        render;
		logic        restart;
		logic        note_wr;
		logic [3:0]  note_ch;
		logic [6:0]  note_key;
		logic        phase_clr;
		logic        drum_load;
		logic        delta_valid;
		logic [31:0] delta_ticks;
		logic        score_end;
	} cmd_t;

	function automatic logic [13:0] note_hz(input logic [6:0] n);
		logic [13:0] r;
		case (n)
			7'd0: r = 14'd8; 7'd1: r = 14'd9; 7'd2: r = 14'd9; 7'd3: r = 14'd10;
			7'd4: r = 14'd10; 7'd5: r = 14'd11; 7'd6: r = 14'd12; 7'd7: r = 14'd12;
			7'd8: r = 14'd13; 7'd9: r = 14'd14; 7'd10: r = 14'd15; 7'd11: r = 14'd15;
			7'd12: r = 14'd16; 7'd13: r = 14'd17; 7'd14: r = 14'd18; 7'd15: r = 14'd19;
			7'd16: r = 14'd21; 7'd17: r = 14'd22; 7'd18: r = 14'd23; 7'd19: r = 14'd24;
			7'd20: r = 14'd26; 7'd21: r = 14'd28; 7'd22: r = 14'd29; 7'd23: r = 14'd31;
			7'd24: r = 14'd33; 7'd25: r = 14'd35; 7'd26: r = 14'd37; 7'd27: r = 14'd39;
			7'd28: r = 14'd41; 7'd29: r = 14'd44; 7'd30: r = 14'd46; 7'd31: r = 14'd49;
			7'd32: r = 14'd52; 7'd33: r = 14'd55; 7'd34: r = 14'd58; 7'd35: r = 14'd62;
			7'd36: r = 14'd65; 7'd37: r = 14'd69; 7'd38: r = 14'd73; 7'd39: r = 14'd78;
			7'd40: r = 14'd82; 7'd41: r = 14'd87; 7'd42: r = 14'd92; 7'd43: r = 14'd98;
			7'd44: r = 14'd104; 7'd45: r = 14'd110; 7'd46: r = 14'd117; 7'd47: r = 14'd123;
			7'd48: r = 14'd131; 7'd49: r = 14'd139; 7'd50: r = 14'd147; 7'd51: r = 14'd156;
			7'd52: r = 14'd165; 7'd53: r = 14'd175; 7'd54: r = 14'd185; 7'd55: r = 14'd196;
			7'd56: r = 14'd208; 7'd57: r = 14'd220; 7'd58: r = 14'd233; 7'd59: r = 14'd247;
			7'd60: r = 14'd262; 7'd61: r = 14'd277; 7'd62: r = 14'd294; 7'd63: r = 14'd311;
			7'd64: r = 14'd330; 7'd65: r = 14'd349; 7'd66: r = 14'd370; 7'd67: r = 14'd392;
			7'd68: r = 14'd415; 7'd69: r = 14'd440; 7'd70: r = 14'd466; 7'd71: r = 14'd494;
			7'd72: r = 14'd523; 7'd73: r = 14'd554; 7'd74: r = 14'd587; 7'd75: r = 14'd622;
			7'd76: r = 14'd659; 7'd77: r = 14'd698; 7'd78: r = 14'd740; 7'd79: r = 14'd784;
			7'd80: r = 14'd831; 7'd81: r = 14'd880; 7'd82: r = 14'd932; 7'd83: r = 14'd988;
			7'd84: r = 14'd1047; 7'd85: r = 14'd1109; 7'd86: r = 14'd1175; 7'd87: r = 14'd1245;
			7'd88: r = 14'd1319; 7'd89: r = 14'd1397; 7'd90: r = 14'd1480; 7'd91: r = 14'd1568;
			7'd92: r = 14'd1661; 7'd93: r = 14'd1760; 7'd94: r = 14'd1865; 7'd95: r = 14'd1976;
			7'd96: r = 14'd2093; 7'd97: r = 14'd2217; 7'd98: r = 14'd2349; 7'd99: r = 14'd2489;
			7'd100: r = 14'd2637; 7'd101: r = 14'd2794; 7'd102: r = 14'd2960;
			7'd103: r = 14'd3136; 7'd104: r = 14'd3322; 7'd105: r = 14'd3520;
			7'd106: r = 14'd3729; 7'd107: r = 14'd3951; 7'd108: r = 14'd4186;
			7'd109: r = 14'd4435; 7'd110: r = 14'd4699; 7'd111: r = 14'd4978;
			7'd112: r = 14'd5274; 7'd113: r = 14'd5588; 7'd114: r = 14'd5920;
			7'd115: r = 14'd6272; 7'd116: r = 14'd6645; 7'd117: r = 14'd7040;
			7'd118: r = 14'd7459; 7'd119: r = 14'd7902; 7'd120: r = 14'd8372;
			7'd121: r = 14'd8870; 7'd122: r = 14'd9397; 7'd123: r = 14'd9956;
			7'd124: r = 14'd10548; 7'd125: r = 14'd11175; 7'd126: r = 14'd11840;
			default: r = 14'd12544;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/mess_front.sv =====
// Front part: accepts input items and runs the score byte parser.
// Depends on mess_pkg; keeps a shadow of the note store to decide releases.
module mess_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  mess_pkg::in_item_t in_item,
	output logic               in_stall,
	output logic               cmd_valid,
	output mess_pkg::cmd_t     cmd,
	input  logic               cmd_full
);
	mess_pkg::phase_t phase_q;
	logic [3:0]  chan_q;
	logic [1:0]  skip_q;
	logic        last_q;
	logic [31:0] delta_q;
	logic        ended_q;
	logic [6:0]  notes_q [16];

	logic [7:0] b;
	logic [6:0] key;
	logic       accept;
	mess_pkg::phase_t phase_d;
	logic [2:0] etype;

	assign in_stall = cmd_full;
	assign accept = in_valid && !cmd_full;
	assign cmd_valid = accept;
	assign b = in_item.score_byte;
	assign key = b[6:0];
	assign etype = b[6:4];

	function automatic mess_pkg::phase_t done_phase(input logic last);
		return last ? mess_pkg::PH_DELTA : mess_pkg::PH_DESC;
	endfunction

	always_comb begin
		cmd = '0;
		phase_d = phase_q;
		cmd.render = (in_item.kind == mess_pkg::KIND_RENDER);
		cmd.restart = (in_item.kind == mess_pkg::KIND_RESTART);
		cmd.note_ch = chan_q;
		cmd.note_key = key;
		if (in_item.kind == mess_pkg::KIND_SCORE && !ended_q) begin
			case (phase_q)
				mess_pkg::PH_DESC: begin
					case (etype)
						mess_pkg::EV_RELEASE: phase_d = mess_pkg::PH_RELEASE;
						mess_pkg::EV_PRESS: phase_d = mess_pkg::PH_PRESS;
						mess_pkg::EV_PITCH, mess_pkg::EV_SYSTEM, mess_pkg::EV_CTRL:
							phase_d = mess_pkg::PH_SKIP;
						default: begin
							phase_d = mess_pkg::PH_DESC;
							cmd.score_end = 1'b1;
						end
					endcase
				end
				mess_pkg::PH_RELEASE: begin
					if (chan_q != mess_pkg::DRUM_CHANNEL && notes_q[chan_q] == key) begin
						cmd.note_wr = 1'b1;
						cmd.note_key = '0;
					end
					phase_d = done_phase(last_q);
				end
				mess_pkg::PH_PRESS: begin
					if (chan_q != mess_pkg::DRUM_CHANNEL) begin
						cmd.note_wr = 1'b1;
						cmd.phase_clr = (notes_q[chan_q] != key);
					end else begin
						cmd.drum_load = 1'b1;
					end
					phase_d = b[7] ? mess_pkg::PH_VELO : done_phase(last_q);
				end
				mess_pkg::PH_VELO: phase_d = done_phase(last_q);
				mess_pkg::PH_SKIP: begin
					if (skip_q <= 2'd1) phase_d = done_phase(last_q);
				end
				mess_pkg::PH_DELTA: begin
					if (!b[7]) begin
						cmd.delta_valid = 1'b1;
						cmd.delta_ticks = {delta_q[24:0], key};
						phase_d = mess_pkg::PH_DESC;
					end
				end
				default: phase_d = mess_pkg::PH_DESC;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mess_pkg::PH_DESC;
			chan_q <= '0;
			skip_q <= '0;
			last_q <= 1'b0;
			delta_q <= '0;
			ended_q <= 1'b0;
			for (int i = 0; i < 16; i++) notes_q[i] <= '0;
		end else if (accept) begin
			if (cmd.restart) begin
				phase_q <= mess_pkg::PH_DESC;
				chan_q <= '0;
				skip_q <= '0;
				last_q <= 1'b0;
				delta_q <= '0;
				ended_q <= 1'b0;
				for (int i = 0; i < 16; i++) notes_q[i] <= '0;
			end else if (in_item.kind == mess_pkg::KIND_SCORE && !ended_q) begin
				phase_q <= phase_d;
				if (cmd.note_wr) notes_q[chan_q] <= cmd.note_key;
				if (cmd.score_end) ended_q <= 1'b1;
				case (phase_q)
					mess_pkg::PH_DESC: begin
						chan_q <= b[3:0];
						last_q <= b[7];
						skip_q <= (etype == mess_pkg::EV_CTRL) ? 2'd2 : 2'd1;
						delta_q <= '0;
					end
					mess_pkg::PH_SKIP: skip_q <= skip_q - 2'd1;
					mess_pkg::PH_DELTA: delta_q <= b[7] ? {delta_q[24:0], key} : '0;
					default: ;
				endcase
			end
		end
	end

	// A score end leaves the parser waiting for a descriptor.
	a_end_desc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.score_end |=> phase_q == mess_pkg::PH_DESC && ended_q)
		else $error("score end did not stop the parser");
	a_delta_desc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.delta_valid |=> phase_q == mess_pkg::PH_DESC)
		else $error("delta did not return to descriptor");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> !(cmd.render && (cmd.note_wr || cmd.delta_valid)))
		else $error("render command carries parser effects");
endmodule

// ===== hdl/mess_queue.sv =====
// Short command queue between the parser and the renderer.
// Depends on mess_pkg for the command type.
module mess_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mess_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           not_empty,
	output mess_pkg::cmd_t head,
	input  logic           pop
);
	localparam int AW = $clog2(DEPTH);
	mess_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue underflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count out of range");
endmodule

// ===== hdl/mess_back.sv =====
// Back part: note and phase store, voice walk, noise, scaling and division.
// Depends on mess_pkg; one command is carried out at a time.
module mess_back #(
	parameter int VOICES = 16,
	parameter int SAMPLE_RATE = 22050
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          volume,
	input  logic [15:0]         drum_burst_length,
	input  logic                cmd_avail,
	input  mess_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                res_valid,
	output mess_pkg::out_item_t res,
	input  logic                res_stall
);
	localparam int NV = (VOICES < 16) ? VOICES : 16;
	localparam logic [15:0] SR = 16'(SAMPLE_RATE);
	localparam logic [15:0] HALF = 16'(SAMPLE_RATE / 2);

	mess_pkg::be_state_t st_q;
	logic [6:0]  notes_q [16];
	logic [15:0] phases_q [16];
	logic [15:0] drum_q;
	logic [31:0] seed_q;
	logic [3:0]  ch_q;
	logic signed [5:0]  sum_q;
	logic [4:0]  nact_q;
	logic        out_v_q;
	mess_pkg::out_item_t out_q;
	logic signed [13:0] prod_q;
	logic [13:0] mag_q;
	logic [13:0] quo_q;
	logic [3:0]  dstep_q;
	logic [13:0] rem_q;
	logic        neg_q;

	logic [16:0] p0, p1, p2;
	logic [6:0]  nt;
	logic        active;
	logic [31:0] seed_nx;
	logic [14:0] trial;
	logic signed [14:0] sv;
	logic signed [14:0] prod_c;
	logic [7:0]  smp;

	assign nt = notes_q[ch_q];
	assign active = (nt != '0) && (ch_q != mess_pkg::DRUM_CHANNEL);
	assign p0 = {1'b0, phases_q[ch_q]} + {3'b0, mess_pkg::note_hz(nt)};
	assign p1 = (p0 >= {1'b0, SR}) ? p0 - {1'b0, SR} : p0;
	assign p2 = (p1 >= {1'b0, SR}) ? p1 - {1'b0, SR} : p1;
	assign seed_nx = seed_q * mess_pkg::LCG_MUL + mess_pkg::LCG_ADD;
	assign prod_c = sum_q * $signed({1'b0, volume});
	assign trial = {rem_q, mag_q[13 - dstep_q]};
	assign cmd_pop = cmd_avail && (st_q == mess_pkg::BE_IDLE) && !out_v_q;
	assign res_valid = out_v_q;
	assign res = out_q;

	always_comb begin
		sv = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		if (sv > 15'sd127) smp = 8'd255;
		else if (sv < -15'sd128) smp = 8'd0;
		else smp = 8'(sv + 15'sd128);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mess_pkg::BE_IDLE;
			for (int i = 0; i < 16; i++) begin
				notes_q[i] <= '0;
				phases_q[i] <= '0;
			end
			drum_q <= '0;
			seed_q <= mess_pkg::SEED_RESET;
			out_v_q <= 1'b0;
			ch_q <= '0;
			sum_q <= '0;
			nact_q <= '0;
		end else begin
			if (out_v_q && !res_stall) out_v_q <= 1'b0;
			case (st_q)
				mess_pkg::BE_IDLE: begin
					if (cmd_pop) begin
						if (cmd.render) begin
							ch_q <= '0;
							sum_q <= '0;
							nact_q <= '0;
							st_q <= mess_pkg::BE_VOICE;
						end else begin
							if (cmd.restart) begin
								for (int i = 0; i < 16; i++) begin
									notes_q[i] <= '0;
									phases_q[i] <= '0;
								end
								drum_q <= '0;
								seed_q <= mess_pkg::SEED_RESET;
							end else begin
								if (cmd.note_wr) notes_q[cmd.note_ch] <= cmd.note_key;
								if (cmd.phase_clr) phases_q[cmd.note_ch] <= '0;
								if (cmd.drum_load) drum_q <= drum_burst_length;
							end
							out_q <= '{sample: 8'h80, sample_valid: 1'b0,
								delta_valid: cmd.delta_valid, delta_ticks: cmd.delta_ticks,
								score_end: cmd.score_end, voice_count: 5'd0};
							out_v_q <= 1'b1;
						end
					end
				end
				mess_pkg::BE_VOICE: begin
					if (active) begin
						phases_q[ch_q] <= p2[15:0];
						sum_q <= sum_q + ((p2[15:0] < HALF) ? 6'sd1 : -6'sd1);
						nact_q <= nact_q + 5'd1;
					end
					if (ch_q == 4'(NV - 1)) st_q <= mess_pkg::BE_NOISE;
					else ch_q <= ch_q + 4'd1;
				end
				mess_pkg::BE_NOISE: begin
					if (drum_q != '0) begin
						seed_q <= seed_nx;
						sum_q <= sum_q + (seed_nx[16] ? 6'sd1 : -6'sd1);
						nact_q <= nact_q + 5'd1;
						drum_q <= drum_q - 16'd1;
					end
					st_q <= mess_pkg::BE_MUL;
				end
				mess_pkg::BE_MUL: begin
					prod_q <= prod_c[13:0];
					neg_q <= sum_q < 0;
					mag_q <= (sum_q < 0) ? 14'(-prod_c) : prod_c[13:0];
					rem_q <= '0;
					quo_q <= '0;
					dstep_q <= '0;
					st_q <= (nact_q == '0) ? mess_pkg::BE_OUT : mess_pkg::BE_DIV;
				end
				mess_pkg::BE_DIV: begin
					// Restoring division, one quotient bit per cycle (truncates toward zero).
					if (trial >= {10'b0, nact_q}) begin
						rem_q <= 14'(trial - {10'b0, nact_q});
						quo_q <= {quo_q[12:0], 1'b1};
					end else begin
						rem_q <= trial[13:0];
						quo_q <= {quo_q[12:0], 1'b0};
					end
					if (dstep_q == 4'd13) st_q <= mess_pkg::BE_OUT;
					dstep_q <= dstep_q + 4'd1;
				end
				mess_pkg::BE_OUT: begin
					out_q <= '{sample: (nact_q == '0) ? 8'h80 : smp, sample_valid: 1'b1,
						delta_valid: 1'b0, delta_ticks: 32'd0, score_end: 1'b0,
						voice_count: nact_q};
					out_v_q <= 1'b1;
					st_q <= mess_pkg::BE_IDLE;
				end
				default: st_q <= mess_pkg::BE_IDLE;
			endcase
		end
	end

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mess_pkg::BE_MUL |-> nact_q <= 5'd16)
		else $error("too many voices");
	a_prod: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mess_pkg::BE_DIV |-> (prod_q < 0) == neg_q || prod_q == 0)
		else $error("sign lost");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mess_pkg::BE_OUT |=> out_v_q && out_q.sample_valid)
		else $error("render result not posted");
endmodule

// ===== hdl/music_event_square_synth_top.sv =====
// Top level of the square-wave music event synthesiser.
// Depends on mess_pkg, mess_front, mess_queue and mess_back.
//
// Usage. Input items (kind, score_byte) arrive on in_valid/in_stall; each transfer
// yields exactly one result on out_valid/out_stall, in order. A transfer happens at
// a clock edge where valid is high and stall is low.
// The front part parses score bytes and issues one command per item into a
// four-entry queue; the back part carries commands out one at a time.
// A score, restart or unused item is carried out by the back part from its idle state.
// A render item walks min(VOICES, 16) channels one a cycle, then takes a noise step,
// a multiply step, the bit-serial divide steps (skipped when no voice is active) and
// an output step; this voice walk and the bit-serial divider set the sustained render
// rate.
// When the receiver stalls, the result register holds, the back part stops taking
// commands, the queue fills and in_stall then rises.
// Reset (arst_n low) clears notes, phases, burst, seed and parser, and sets volume
// to 100 and drum_burst_length to 551. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the next edge and should only be made when idle.
module music_event_square_synth_top #(
	parameter int VOICES = 16,
	parameter int SAMPLE_RATE = 22050
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mess_pkg::in_item_t  in_item,
	output logic                in_stall,
	output logic                out_valid,
	output mess_pkg::out_item_t out_item,
	input  logic                out_stall,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	logic [7:0]  volume_q;
	logic [15:0] burst_q;
	logic           cmd_push, q_full, q_ne, q_pop;
	mess_pkg::cmd_t cmd_in, cmd_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= mess_pkg::VOLUME_RESET;
			burst_q <= mess_pkg::BURST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mess_pkg::REG_VOLUME: volume_q <= cfg_data[7:0];
				mess_pkg::REG_BURST: burst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mess_front u_front (
		.clk, .arst_n, .in_valid, .in_item, .in_stall,
		.cmd_valid(cmd_push), .cmd(cmd_in), .cmd_full(q_full)
	);

	mess_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n, .push(cmd_push), .push_cmd(cmd_in), .full(q_full),
		.not_empty(q_ne), .head(cmd_head), .pop(q_pop)
	);

	mess_back #(.VOICES(VOICES), .SAMPLE_RATE(SAMPLE_RATE)) u_back (
		.clk, .arst_n, .volume(volume_q), .drum_burst_length(burst_q),
		.cmd_avail(q_ne), .cmd(cmd_head), .cmd_pop(q_pop),
		.res_valid(out_valid), .res(out_item), .res_stall(out_stall)
	);
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for music_event_square_synth_top.
// Depends on mess_pkg and the block's RTL; a scoreboard class predicts every result.

class synth_scoreboard;
	logic [7:0]  volume;
	logic [15:0] burst_len;
	logic [6:0]  notes [16];
	logic [31:0] phases [16];
	logic [15:0] drum_left;
	logic [31:0] seed;
	mess_pkg::phase_t phase;
	logic [3:0]  chan;
	logic [1:0]  skip_left;
	logic        last_flag;
	logic [31:0] delta_acc;
	logic        ended;
	mess_pkg::out_item_t pending [$];
	int          errors;

	function void clear_voices();
		for (int i = 0; i < 16; i++) begin
			notes[i] = '0;
			phases[i] = '0;
		end
		drum_left = '0;
		seed = mess_pkg::SEED_RESET;
		phase = mess_pkg::PH_DESC;
		chan = '0;
		skip_left = '0;
		last_flag = 1'b0;
		delta_acc = '0;
		ended = 1'b0;
	endfunction

	function void reset_all();
		volume = mess_pkg::VOLUME_RESET;
		burst_len = mess_pkg::BURST_RESET;
		clear_voices();
		pending.delete();
		errors = 0;
	endfunction

	function void write_reg(logic [0:0] idx, logic [15:0] data);
		if (idx == mess_pkg::REG_VOLUME)
			volume = data[7:0];
		else
			burst_len = data;
	endfunction

	function void finish_event();
		if (last_flag) begin
			delta_acc = '0;
			phase = mess_pkg::PH_DELTA;
		end else begin
			phase = mess_pkg::PH_DESC;
		end
	endfunction

	function void parse_score(logic [7:0] b, ref mess_pkg::out_item_t r);
		logic [6:0] key;
		logic [2:0] etype;
		key = b[6:0];
		if (ended)
			return;
		case (phase)
			mess_pkg::PH_DESC: begin
				chan = b[3:0];
				etype = b[6:4];
				last_flag = b[7];
				if (etype == mess_pkg::EV_RELEASE)
					phase = mess_pkg::PH_RELEASE;
				else if (etype == mess_pkg::EV_PRESS)
					phase = mess_pkg::PH_PRESS;
				else if (etype == mess_pkg::EV_PITCH || etype == mess_pkg::EV_SYSTEM) begin
					skip_left = 2'd1;
					phase = mess_pkg::PH_SKIP;
				end else if (etype == mess_pkg::EV_CTRL) begin
					skip_left = 2'd2;
					phase = mess_pkg::PH_SKIP;
				end else begin
					ended = 1'b1;
					phase = mess_pkg::PH_DESC;
					r.score_end = 1'b1;
				end
			end
			mess_pkg::PH_RELEASE: begin
				if (chan != mess_pkg::DRUM_CHANNEL && notes[chan] == key)
					notes[chan] = '0;
				finish_event();
			end
			mess_pkg::PH_PRESS: begin
				if (chan != mess_pkg::DRUM_CHANNEL) begin
					if (notes[chan] != key)
						phases[chan] = '0;
					notes[chan] = key;
				end else begin
					drum_left = burst_len;
				end
				if (b[7])
					phase = mess_pkg::PH_VELO;
				else
					finish_event();
			end
			mess_pkg::PH_VELO: finish_event();
			mess_pkg::PH_SKIP: begin
				if (skip_left > 2'd1)
					skip_left--;
				else begin
					skip_left = '0;
					finish_event();
				end
			end
			default: begin
				delta_acc = delta_acc * 128 + key;
				if (!b[7]) begin
					r.delta_valid = 1'b1;
					r.delta_ticks = delta_acc;
					delta_acc = '0;
					phase = mess_pkg::PH_DESC;
				end
			end
		endcase
	endfunction

	function void render_sample(ref mess_pkg::out_item_t r);
		int sum, count, v;
		logic [31:0] p;
		sum = 0;
		count = 0;
		for (int ch = 0; ch < 15; ch++) begin
			if (notes[ch] != 0) begin
				p = phases[ch] + mess_pkg::note_hz(notes[ch]);
				if (p >= 22050) p -= 22050;
				if (p >= 22050) p -= 22050;
				phases[ch] = p;
				sum += (p < 11025) ? 1 : -1;
				count++;
			end
		end
		if (drum_left != 0) begin
			seed = seed * mess_pkg::LCG_MUL + mess_pkg::LCG_ADD;
			sum += seed[16] ? 1 : -1;
			count++;
			drum_left--;
		end
		if (count != 0) begin
			v = (sum * int'(volume)) / count;
			if (v > 127) v = 127;
			else if (v < -128) v = -128;
			r.sample = 8'(128 + v);
		end
		r.sample_valid = 1'b1;
		r.voice_count = 5'(count);
	endfunction

	function void note_input(mess_pkg::in_item_t it);
		mess_pkg::out_item_t r;
		r = '0;
		r.sample = 8'h80;
		if (it.kind == mess_pkg::KIND_SCORE)
			parse_score(it.score_byte, r);
		else if (it.kind == mess_pkg::KIND_RENDER)
			render_sample(r);
		else if (it.kind == mess_pkg::KIND_RESTART)
			clear_voices();
		pending.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	task check_result(mess_pkg::out_item_t got);
		mess_pkg::out_item_t w;
		if (pending.size() == 0) begin
			report("unexpected result", 32'd1, 32'd0);
			return;
		end
		w = pending.pop_front();
		if (got.sample !== w.sample) report("sample", got.sample, w.sample);
		if (got.sample_valid !== w.sample_valid)
			report("sample_valid", got.sample_valid, w.sample_valid);
		if (got.delta_valid !== w.delta_valid)
			report("delta_valid", got.delta_valid, w.delta_valid);
		if (got.delta_ticks !== w.delta_ticks)
			report("delta_ticks", got.delta_ticks, w.delta_ticks);
		if (got.score_end !== w.score_end) report("score_end", got.score_end, w.score_end);
		if (got.voice_count !== w.voice_count)
			report("voice_count", got.voice_count, w.voice_count);
	endtask
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	mess_pkg::in_item_t in_item = '0;
	logic in_stall;
	logic out_valid;
	mess_pkg::out_item_t out_item;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	synth_scoreboard sb;
	// Idle percentage for both sides; dropped to zero for a quiet stretch.
	int idle_pct = 36;
	int quiet_cycles = 0;
	bit all_sent = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	music_event_square_synth_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
		.out_valid(out_valid), .out_item(out_item), .out_stall(out_stall),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The receiver stalls at random; results are checked at the edge of transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_item);
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// A watchdog on cycles without any transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one item, holds it steady until the transfer, then maybe idles.
	task send_item(logic [1:0] kind, logic [7:0] b);
		mess_pkg::in_item_t it;
		it.kind = kind;
		it.score_byte = b;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			in_item <= mess_pkg::in_item_t'(10'($urandom));
			@(posedge clk);
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task write_cfg(logic [0:0] idx, logic [15:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// A well-formed event with random content, occasionally ending its block.
	task send_event(bit allow_end);
		logic [7:0] d;
		logic [2:0] et;
		logic [3:0] ch;
		int n;
		et = 3'($urandom_range(allow_end ? 7 : 4));
		ch = ($urandom_range(5) == 0) ? mess_pkg::DRUM_CHANNEL : 4'($urandom_range(14));
		d = {($urandom_range(3) == 0), et, ch};
		send_item(mess_pkg::KIND_SCORE, d);
		case (et)
			mess_pkg::EV_RELEASE, mess_pkg::EV_PRESS:
				send_item(mess_pkg::KIND_SCORE, 8'($urandom));
			mess_pkg::EV_PITCH, mess_pkg::EV_SYSTEM:
				send_item(mess_pkg::KIND_SCORE, 8'($urandom));
			mess_pkg::EV_CTRL: begin
				send_item(mess_pkg::KIND_SCORE, 8'($urandom));
				send_item(mess_pkg::KIND_SCORE, 8'($urandom));
			end
			default: ;
		endcase
		if (d[7] && et <= mess_pkg::EV_CTRL) begin
			n = $urandom_range(4);
			repeat (n) send_item(mess_pkg::KIND_SCORE, 8'($urandom) | 8'h80);
			send_item(mess_pkg::KIND_SCORE, 8'($urandom) & 8'h7F);
		end
	endtask

	initial begin
		int r;
		sb = new();
		sb.reset_all();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: notes on both ends of the key range, a velocity byte, a drum
		// press, release, skips, a long wrapping delta, end of score and restart.
		send_item(mess_pkg::KIND_RENDER, 8'h00);
		send_item(mess_pkg::KIND_SCORE, 8'h10);
		send_item(mess_pkg::KIND_SCORE, 8'h7F);
		send_item(mess_pkg::KIND_SCORE, 8'h11);
		send_item(mess_pkg::KIND_SCORE, 8'h81);
		send_item(mess_pkg::KIND_SCORE, 8'h55);
		send_item(mess_pkg::KIND_SCORE, 8'h1F);
		send_item(mess_pkg::KIND_SCORE, 8'h40);
		send_item(mess_pkg::KIND_RENDER, 8'hFF);
		send_item(mess_pkg::KIND_SCORE, 8'h00);
		send_item(mess_pkg::KIND_SCORE, 8'h7F);
		send_item(mess_pkg::KIND_SCORE, 8'hA2);
		send_item(mess_pkg::KIND_SCORE, 8'hFF);
		repeat (5) send_item(mess_pkg::KIND_SCORE, 8'hFF);
		send_item(mess_pkg::KIND_SCORE, 8'h7F);
		send_item(mess_pkg::KIND_SCORE, 8'hCE);
		send_item(mess_pkg::KIND_SCORE, 8'h00);
		send_item(mess_pkg::KIND_SCORE, 8'h01);
		send_item(mess_pkg::KIND_SCORE, 8'h00);
		send_item(mess_pkg::KIND_SCORE, 8'hF0);
		send_item(mess_pkg::KIND_SCORE, 8'h10);
		send_item(mess_pkg::KIND_RENDER, 8'h00);
		send_item(mess_pkg::KIND_UNUSED, 8'hAA);
		send_item(mess_pkg::KIND_RESTART, 8'h00);

		// Random phases under several register settings, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_cfg(mess_pkg::REG_VOLUME, 16'd255);
					write_cfg(mess_pkg::REG_BURST, 16'd0);
				end
				1: begin
					write_cfg(mess_pkg::REG_VOLUME, 16'd0);
					write_cfg(mess_pkg::REG_BURST, 16'hFFFF);
				end
				2: begin
					write_cfg(mess_pkg::REG_VOLUME, 16'd1);
					write_cfg(mess_pkg::REG_BURST, 16'd20);
				end
				3: write_cfg(mess_pkg::REG_VOLUME, 16'($urandom_range(255)));
				default: write_cfg(mess_pkg::REG_BURST, 16'($urandom_range(600)));
			endcase
			idle_pct = (ph == 2) ? 0 : 36;
			for (int k = 0; k < 35; k++) begin
				r = $urandom_range(99);
				if (r < 45)
					send_event(k > 30);
				else if (r < 85)
					send_item(mess_pkg::KIND_RENDER, 8'($urandom));
				else if (r < 88)
					send_item(mess_pkg::KIND_RESTART, 8'($urandom));
				else
					send_item(2'($urandom), 8'($urandom));
			end
			send_item(mess_pkg::KIND_RESTART, 8'h00);
		end
		drain();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
